>>> hdl/pyp_pkg.sv
// Shared constants, types and helper functions of the pinhole yaw projection block.
package pyp_pkg;

	localparam int CW     = 32;
	localparam int FRAC   = 16;
	localparam int DW     = 32;
	localparam int ADDR_W = 5;
	localparam int IDX_W  = 3;
	localparam int YAW_W  = 16;

	localparam int CS_W = 20;
	localparam int PW   = CW + CS_W;
	localparam int UW   = PW + 2;
	localparam int LO_W = UW / 2;
	localparam int HI_W = UW - LO_W;
	localparam int NW   = CW + UW;
	localparam int NUMW = NW + 2;
	localparam int DENW = UW + 1;
	localparam int QB   = CW + 2;
	localparam int SUMW = QB + 2;
	localparam int NYW  = 2 * CW + 1;

	localparam int XW     = 34;
	localparam int ZW     = 36;
	localparam int STEPS  = 30;
	localparam int STEP_W = 5;
	localparam int ANG_SH = 17;
	localparam int RND_SH = 14;

	localparam logic signed [XW-1:0] CORDIC_GAIN = 34'sd652032874;
	localparam logic signed [ZW-1:0] Q30_PI      = 36'sd3373259426;
	localparam logic signed [ZW-1:0] Q30_HALF_PI = 36'sd1686629713;
	localparam logic signed [XW-1:0] RND_BIAS    = 34'sd8192;

	localparam logic [IDX_W-1:0] REG_FOCAL_X  = 3'd0;
	localparam logic [IDX_W-1:0] REG_FOCAL_Y  = 3'd1;
	localparam logic [IDX_W-1:0] REG_OFFSET_X = 3'd2;
	localparam logic [IDX_W-1:0] REG_OFFSET_Y = 3'd3;
	localparam logic [IDX_W-1:0] REG_SHIFT_X  = 3'd4;
	localparam logic [IDX_W-1:0] REG_SHIFT_Y  = 3'd5;
	localparam logic [IDX_W-1:0] REG_SHIFT_Z  = 3'd6;
	localparam logic [IDX_W-1:0] REG_YAW      = 3'd7;

	localparam logic signed [CW-1:0] FOCAL_RESET = CW'(500 * 65536);
	localparam logic signed [CW-1:0] SMAX = {1'b0, {(CW-1){1'b1}}};
	localparam logic signed [CW-1:0] SMIN = {1'b1, {(CW-1){1'b0}}};

	typedef struct packed {
		logic                   busy;
		logic signed [CS_W-1:0] cos_v;
		logic signed [CS_W-1:0] sin_v;
	} cs_t;

	typedef struct packed {
		logic ovf_x;
		logic ovf_y;
		logic neg_x;
		logic neg_y;
		logic nneg_x;
		logic nneg_y;
		logic nz_x;
		logic nz_y;
		logic dz;
	} side_t;

	function automatic logic signed [ZW-1:0] atan_step(input logic [STEP_W-1:0] i);
		logic signed [ZW-1:0] r;
		case (i)
			5'd0:    r = 36'sd843314857;
			5'd1:    r = 36'sd497837830;
			5'd2:    r = 36'sd263043837;
			5'd3:    r = 36'sd133525159;
			5'd4:    r = 36'sd67021687;
			5'd5:    r = 36'sd33543516;
			5'd6:    r = 36'sd16775851;
			5'd7:    r = 36'sd8388437;
			5'd8:    r = 36'sd4194283;
			5'd9:    r = 36'sd2097149;
			5'd10:   r = 36'sd1048576;
			default: r = ZW'(1) << (5'd30 - i);
		endcase
		return r;
	endfunction

	function automatic logic [CW-1:0] finish(input logic [QB-1:0] q, input logic ovf,
			input logic neg, input logic dz, input logic nneg, input logic nz,
			input logic signed [CW-1:0] off);
		logic signed [QB:0]     qs;
		logic signed [SUMW-1:0] sum;
		logic [CW-1:0]          r;
		qs = $signed({1'b0, q});
		if (neg) begin
			qs = -qs;
		end
		sum = SUMW'(qs) + SUMW'(off);
		if (dz) begin
			r = nz ? '0 : (nneg ? SMIN : SMAX);
		end else if (ovf) begin
			r = neg ? SMIN : SMAX;
		end else if (sum > SUMW'(SMAX)) begin
			r = SMAX;
		end else if (sum < SUMW'(SMIN)) begin
			r = SMIN;
		end else begin
			r = sum[CW-1:0];
		end
		return r;
	endfunction

endpackage

>>> hdl/pyp_cordic.sv
// Sequential rotation-mode CORDIC that turns the yaw register into Q16 cosine and sine.
module pyp_cordic (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [pyp_pkg::YAW_W-1:0] yaw,
	output pyp_pkg::cs_t              cs
);
	import pyp_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_LOAD = 2'd1;
	localparam logic [1:0] ST_RUN  = 2'd2;
	localparam logic [1:0] ST_DONE = 2'd3;

	logic [1:0]             state_q;
	logic [STEP_W-1:0]      step_q;
	logic                   flip_q;
	logic signed [XW-1:0]   x_q, y_q;
	logic signed [ZW-1:0]   z_q;
	logic signed [CS_W-1:0] cos_q, sin_q;

	logic signed [ZW-1:0] z0;
	logic signed [XW-1:0] dx, dy, xf, yf, xr, yr;

	always_comb begin
		z0 = ZW'($signed(yaw)) <<< ANG_SH;
		dx = y_q >>> step_q;
		dy = x_q >>> step_q;
		xf = flip_q ? -x_q : x_q;
		yf = flip_q ? -y_q : y_q;
		xr = xf + RND_BIAS;
		yr = yf + RND_BIAS;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			step_q  <= '0;
		end else if (start) begin
			state_q <= ST_LOAD;
		end else begin
			case (state_q)
				ST_IDLE: state_q <= ST_IDLE;
				ST_LOAD: begin
					step_q  <= '0;
					state_q <= ST_RUN;
				end
				ST_RUN: begin
					step_q <= step_q + 1'b1;
					if (step_q == STEP_W'(STEPS - 1)) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_LOAD: begin
				x_q <= CORDIC_GAIN;
				y_q <= '0;
				// fold angles beyond a quarter turn, negate results at the end
				if (z0 > Q30_HALF_PI) begin
					z_q    <= z0 - Q30_PI;
					flip_q <= 1'b1;
				end else if (z0 < -Q30_HALF_PI) begin
					z_q    <= z0 + Q30_PI;
					flip_q <= 1'b1;
				end else begin
					z_q    <= z0;
					flip_q <= 1'b0;
				end
			end
			ST_RUN: begin
				if (!z_q[ZW-1]) begin
					x_q <= x_q - dx;
					y_q <= y_q + dy;
					z_q <= z_q - atan_step(step_q);
				end else begin
					x_q <= x_q + dx;
					y_q <= y_q - dy;
					z_q <= z_q + atan_step(step_q);
				end
			end
			ST_DONE: begin
				cos_q <= CS_W'(xr >>> RND_SH);
				sin_q <= CS_W'(yr >>> RND_SH);
			end
			default: begin
				cos_q <= cos_q;
			end
		endcase
	end

	assign cs.busy  = (state_q != ST_IDLE);
	assign cs.cos_v = cos_q;
	assign cs.sin_v = sin_q;

endmodule

>>> hdl/pyp_div.sv
// Pipelined restoring divider, one quotient bit per stage.
module pyp_div (
	input  logic                     clk,
	input  logic                     en,
	input  logic [pyp_pkg::NUMW-1:0] num,
	input  logic [pyp_pkg::DENW-1:0] den,
	output logic [pyp_pkg::QB-1:0]   quo
);
	import pyp_pkg::*;

	logic [NUMW-1:0] rem_s [QB];
	logic [DENW-1:0] den_s [QB];
	logic [QB-1:0]   quo_s [QB];

	for (genvar j = 0; j < QB; j++) begin : g_stage
		localparam int K = QB - 1 - j;
		logic [NUMW-1:0] r_in, trial;
		logic [DENW-1:0] d_in;
		logic [QB-1:0]   q_in;
		logic            take;

		if (j == 0) begin : g_first
			assign r_in = num;
			assign d_in = den;
			assign q_in = '0;
		end else begin : g_next
			assign r_in = rem_s[j-1];
			assign d_in = den_s[j-1];
			assign q_in = quo_s[j-1];
		end

		assign trial = NUMW'(d_in) << K;
		assign take  = (r_in >= trial);

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[j] <= take ? r_in - trial : r_in;
				den_s[j] <= d_in;
				quo_s[j] <= {q_in[QB-2:0], take};
			end
		end
	end

	assign quo = quo_s[QB-1];

endmodule

>>> hdl/pinhole_yaw_point_projection_top.sv
// Top level of the pinhole yaw point projection: register port, pipeline and output register.
//
// Usage
//   Input channel (in_valid / in_stall) carries one world point per beat:
//   point_x, point_y, point_z, signed Q16.16. Output channel (out_valid /
//   out_stall) returns one beat per point: image_x, image_y (signed Q16.16,
//   saturated) and depth_zero, in input order.
//   Configuration goes through the APB port, registers at byte address 4*i:
//   focal_x, focal_y, offset_x, offset_y, shift_x, shift_y, shift_z, yaw.
//   Write them only while no point is in flight.
//   Throughput: one point per cycle while in_stall is low. Pipeline depth:
//   8 arithmetic stages, 34 divider stages and the output register;
//   the divider's one-bit-per-stage quotient sets the depth.
//   Cosine and sine of the yaw come from a 30-step CORDIC that runs after
//   reset and after every yaw write; in_stall is high meanwhile.
//   A stalled receiver holds the output register; the pipeline keeps moving
//   until a result reaches the stage in front of it, then everything holds
//   and in_stall rises. Reset empties the pipeline and loads the register
//   defaults (focal lengths 500.0, everything else zero).
module pinhole_yaw_point_projection_top (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [pyp_pkg::ADDR_W-1:0] paddr,
	input  logic [pyp_pkg::DW-1:0]     pwdata,
	output logic [pyp_pkg::DW-1:0]     prdata,
	output logic                       pready,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic signed [pyp_pkg::CW-1:0] point_x,
	input  logic signed [pyp_pkg::CW-1:0] point_y,
	input  logic signed [pyp_pkg::CW-1:0] point_z,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic signed [pyp_pkg::CW-1:0] image_x,
	output logic signed [pyp_pkg::CW-1:0] image_y,
	output logic                       depth_zero
);
	import pyp_pkg::*;

	// configuration registers
	logic signed [CW-1:0] focal_x_q, focal_y_q, offset_x_q, offset_y_q;
	logic signed [CW-1:0] shift_x_q, shift_y_q, shift_z_q;
	logic [YAW_W-1:0]     yaw_q;
	logic                 wr;
	logic [IDX_W-1:0]     idx;
	logic                 start;
	cs_t                  cs;
	logic signed [CS_W-1:0] cos_w, sin_w;

	// handshake and advance
	logic adv, ld_out, take_in;

	// pipeline
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;
	logic signed [CW-1:0]   x_s1, y_s1, z_s1;
	logic signed [PW-1:0]   pxc_s2, pzs_s2, pzc_s2, pxs_s2;
	logic signed [CW:0]     ysum_s2;
	logic signed [UW-1:0]   u_s3, d_s3, d_s4, d_s5;
	logic signed [NYW-1:0]  nyp_s3, nyp_s4;
	logic signed [CW+LO_W:0]  plo_s4;
	logic signed [CW+HI_W-1:0] phi_s4;
	logic signed [NW-1:0]   nx_s5, ny_s5;
	logic [NW-1:0]          ax_s6, ay_s6;
	logic [UW-1:0]          ad_s6;
	side_t                  side_s6, side_s7, side_s8;
	side_t                  side_c8;
	logic [NUMW-1:0]        numx_s7, numy_s7, numx_s8, numy_s8;
	logic [DENW-1:0]        den_s7, den_s8;
	logic [QB-1:0]          v_dv;
	side_t                  side_dv [QB];
	logic [QB-1:0]          qx, qy;
	logic signed [LO_W:0]   ulo;
	logic signed [HI_W-1:0] uhi;

	// output register
	logic                 out_valid_q, depth_zero_q;
	logic [CW-1:0]        image_x_q, image_y_q;
	logic [CW-1:0]        res_x, res_y;

	// register port
	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite;
	assign idx    = paddr[ADDR_W-1:2];
	assign start  = wr && (idx == REG_YAW);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			focal_x_q  <= FOCAL_RESET;
			focal_y_q  <= FOCAL_RESET;
			offset_x_q <= '0;
			offset_y_q <= '0;
			shift_x_q  <= '0;
			shift_y_q  <= '0;
			shift_z_q  <= '0;
			yaw_q      <= '0;
		end else if (wr) begin
			case (idx)
				REG_FOCAL_X:  focal_x_q  <= pwdata[CW-1:0];
				REG_FOCAL_Y:  focal_y_q  <= pwdata[CW-1:0];
				REG_OFFSET_X: offset_x_q <= pwdata[CW-1:0];
				REG_OFFSET_Y: offset_y_q <= pwdata[CW-1:0];
				REG_SHIFT_X:  shift_x_q  <= pwdata[CW-1:0];
				REG_SHIFT_Y:  shift_y_q  <= pwdata[CW-1:0];
				REG_SHIFT_Z:  shift_z_q  <= pwdata[CW-1:0];
				REG_YAW:      yaw_q      <= pwdata[YAW_W-1:0];
				default:      yaw_q      <= yaw_q;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_FOCAL_X:  prdata = DW'(focal_x_q);
			REG_FOCAL_Y:  prdata = DW'(focal_y_q);
			REG_OFFSET_X: prdata = DW'(offset_x_q);
			REG_OFFSET_Y: prdata = DW'(offset_y_q);
			REG_SHIFT_X:  prdata = DW'(shift_x_q);
			REG_SHIFT_Y:  prdata = DW'(shift_y_q);
			REG_SHIFT_Z:  prdata = DW'(shift_z_q);
			REG_YAW:      prdata = DW'(yaw_q);
			default:      prdata = '0;
		endcase
	end

	// cosine and sine of the yaw, recomputed after every yaw write
	pyp_cordic u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.yaw    (yaw_q),
		.cs     (cs)
	);

	assign cos_w = cs.cos_v;
	assign sin_w = cs.sin_v;

	// Advance the pipeline unless the result in front of a stalled output
	// register has nowhere to go.
	assign ld_out   = !out_valid_q || !out_stall;
	assign adv      = ld_out || !v_dv[QB-1];
	assign in_stall = cs.busy || !adv;
	assign take_in  = in_valid && !in_stall;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
			v_dv <= '0;
		end else if (adv) begin
			v_s1 <= take_in;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
			v_dv <= {v_dv[QB-2:0], v_s8};
		end
	end

	assign ulo = $signed({1'b0, u_s3[LO_W-1:0]});
	assign uhi = u_s3[UW-1:LO_W];

	// flag quotients too large for the divider, they saturate anyway
	always_comb begin
		side_c8       = side_s7;
		side_c8.ovf_x = {1'b0, numx_s7} >= ((NUMW+1)'(den_s7) << QB);
		side_c8.ovf_y = {1'b0, numy_s7} >= ((NUMW+1)'(den_s7) << QB);
	end

	// arithmetic stages
	always_ff @(posedge clk) begin
		if (adv) begin
			// s1: capture the point
			x_s1 <= point_x;
			y_s1 <= point_y;
			z_s1 <= point_z;
			// s2: rotate by the yaw, add shift_y to y
			pxc_s2  <= PW'(x_s1 * cos_w);
			pzs_s2  <= PW'(z_s1 * sin_w);
			pzc_s2  <= PW'(z_s1 * cos_w);
			pxs_s2  <= PW'(x_s1 * sin_w);
			ysum_s2 <= (CW+1)'(y_s1) + (CW+1)'(shift_y_q);
			// s3: bracketed x term and depth in Q32, y numerator product
			u_s3   <= (UW'(shift_x_q) <<< FRAC) + UW'(pxc_s2) + UW'(pzs_s2);
			d_s3   <= (UW'(shift_z_q) <<< FRAC) + UW'(pzc_s2) - UW'(pxs_s2);
			nyp_s3 <= NYW'(focal_y_q * ysum_s2);
			// s4: split focal_x * u into two partial products
			plo_s4 <= (CW+LO_W+1)'(focal_x_q * ulo);
			phi_s4 <= (CW+HI_W)'(focal_x_q * uhi);
			d_s4   <= d_s3;
			nyp_s4 <= nyp_s3;
			// s5: join the partial products, numerators in Q48
			nx_s5 <= (NW'(phi_s4) <<< LO_W) + NW'(plo_s4);
			ny_s5 <= NW'(nyp_s4) <<< FRAC;
			d_s5  <= d_s4;
			// s6: magnitudes and signs
			ax_s6          <= nx_s5[NW-1] ? -nx_s5 : nx_s5;
			ay_s6          <= ny_s5[NW-1] ? -ny_s5 : ny_s5;
			ad_s6          <= d_s5[UW-1] ? -d_s5 : d_s5;
			side_s6.ovf_x  <= 1'b0;
			side_s6.ovf_y  <= 1'b0;
			side_s6.neg_x  <= nx_s5[NW-1] ^ d_s5[UW-1];
			side_s6.neg_y  <= ny_s5[NW-1] ^ d_s5[UW-1];
			side_s6.nneg_x <= nx_s5[NW-1];
			side_s6.nneg_y <= ny_s5[NW-1];
			side_s6.nz_x   <= (nx_s5 == '0);
			side_s6.nz_y   <= (ny_s5 == '0);
			side_s6.dz     <= (d_s5 == '0);
			// s7: round to nearest by dividing (2|n| + |d|) by 2|d|
			numx_s7 <= (NUMW'(ax_s6) << 1) + NUMW'(ad_s6);
			numy_s7 <= (NUMW'(ay_s6) << 1) + NUMW'(ad_s6);
			den_s7  <= DENW'(ad_s6) << 1;
			side_s7 <= side_s6;
			// s8: carry the operands and the overflow flags
			numx_s8 <= numx_s7;
			numy_s8 <= numy_s7;
			den_s8  <= den_s7;
			side_s8 <= side_c8;
		end
	end

	// flags ride alongside the divider stages
	always_ff @(posedge clk) begin
		if (adv) begin
			side_dv[0] <= side_s8;
			for (int i = 1; i < QB; i++) begin
				side_dv[i] <= side_dv[i-1];
			end
		end
	end

	pyp_div u_div_x (
		.clk (clk),
		.en  (adv),
		.num (numx_s8),
		.den (den_s8),
		.quo (qx)
	);

	pyp_div u_div_y (
		.clk (clk),
		.en  (adv),
		.num (numy_s8),
		.den (den_s8),
		.quo (qy)
	);

	// sign, offset and saturation
	assign res_x = finish(qx, side_dv[QB-1].ovf_x, side_dv[QB-1].neg_x, side_dv[QB-1].dz,
		side_dv[QB-1].nneg_x, side_dv[QB-1].nz_x, offset_x_q);
	assign res_y = finish(qy, side_dv[QB-1].ovf_y, side_dv[QB-1].neg_y, side_dv[QB-1].dz,
		side_dv[QB-1].nneg_y, side_dv[QB-1].nz_y, offset_y_q);

	// output register: hold while the receiver stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ld_out) begin
			out_valid_q <= v_dv[QB-1];
		end
	end

	always_ff @(posedge clk) begin
		if (ld_out) begin
			image_x_q    <= res_x;
			image_y_q    <= res_y;
			depth_zero_q <= side_dv[QB-1].dz;
		end
	end

	assign out_valid  = out_valid_q;
	assign image_x    = image_x_q;
	assign image_y    = image_y_q;
	assign depth_zero = depth_zero_q;

endmodule

>>> hdl/pyp_checker.sv
// Port-level checker for the projection block and its bind statement.
module pyp_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       psel,
	input logic                       penable,
	input logic                       pwrite,
	input logic [pyp_pkg::ADDR_W-1:0] paddr,
	input logic                       in_stall,
	input logic                       out_valid,
	input logic                       out_stall,
	input logic [pyp_pkg::CW-1:0]     image_x,
	input logic [pyp_pkg::CW-1:0]     image_y,
	input logic                       depth_zero
);
	import pyp_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(image_x) && $stable(image_y)
			&& $stable(depth_zero))
		else $error("stalled output beat changed");

	a_yaw_stall: assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable && pwrite && (paddr[ADDR_W-1:2] == REG_YAW) |=> in_stall)
		else $error("input taken while yaw is recomputed");

	a_zero_x: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && depth_zero |-> (image_x == SMAX) || (image_x == SMIN) || (image_x == '0))
		else $error("zero depth without saturated image_x");

	a_zero_y: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && depth_zero |-> (image_y == SMAX) || (image_y == SMIN) || (image_y == '0))
		else $error("zero depth without saturated image_y");

endmodule

bind pinhole_yaw_point_projection_top pyp_checker u_pyp_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.psel       (psel),
	.penable    (penable),
	.pwrite     (pwrite),
	.paddr      (paddr),
	.in_stall   (in_stall),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.image_x    (image_x),
	.image_y    (image_y),
	.depth_zero (depth_zero)
);
